>>> design/nnt_pkg.sv
package nnt_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int COST_BITS_DEF = 32;

    localparam int            NODE_COUNT_W   = 5;
    localparam logic [4:0]    NODE_COUNT_RST = 5'd16;
    localparam int            APB_ADDR_W     = 3;
    localparam int            APB_DATA_W     = 32;
    localparam logic          REG_NODE_COUNT = 1'b0;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_START = 1'b1
    } req_t;

    typedef struct packed {
        logic        last;
        logic [31:0] cost;
        logic [3:0]  node;
    } res_t;

endpackage

>>> design/nnt_cost_ram.sv
module nnt_cost_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/nnt_scan.sv
module nnt_scan #(
    parameter int MAX_NODES = 16,
    parameter int COST_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [nnt_pkg::NODE_COUNT_W-1:0] node_count,
    input  logic [3:0]                     start_node,
    output logic                           busy,
    output logic                           rd_en,
    output logic [2*$clog2(MAX_NODES)-1:0] rd_addr,
    input  logic [COST_BITS-1:0]           rd_data,
    output logic                           res_valid,
    output nnt_pkg::res_t                  res,
    input  logic                           res_ready
);
    import nnt_pkg::*;

    localparam int NODE_BITS = $clog2(MAX_NODES);
    localparam int CNT_BITS  = $clog2(MAX_NODES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_FINISH,
        ST_CLOSE_RD,
        ST_CLOSE_WAIT
    } state_t;

    state_t                 state_reg;
    logic [CNT_BITS-1:0]    n_reg;
    logic [CNT_BITS-1:0]    pos_reg;
    logic [NODE_BITS-1:0]   cur_reg;
    logic [NODE_BITS-1:0]   first_reg;
    logic [NODE_BITS-1:0]   idx_reg;
    logic [MAX_NODES-1:0]   visited_reg;
    logic                   rd_valid_reg;
    logic [NODE_BITS-1:0]   rd_idx_reg;
    logic                   have_reg;
    logic [NODE_BITS-1:0]   best_reg;
    logic [COST_BITS-1:0]   best_cost_reg;
    res_t                   res_reg;

    logic [31:0]            cnt_ext;
    logic [31:0]            n_sat;
    logic [31:0]            start_ext;
    logic [31:0]            start_sat;
    logic                   scan_last;
    logic                   take;

    always_comb begin
        cnt_ext   = 32'(node_count);
        start_ext = 32'(start_node);
        if (cnt_ext < 32'd2) begin
            n_sat = 32'd2;
        end else if (cnt_ext > 32'(MAX_NODES)) begin
            n_sat = 32'(MAX_NODES);
        end else begin
            n_sat = cnt_ext;
        end
        if (start_ext >= n_sat) begin
            start_sat = n_sat - 32'd1;
        end else begin
            start_sat = start_ext;
        end
    end

    assign scan_last = (CNT_BITS'(idx_reg) == n_reg - CNT_BITS'(1));
    assign take      = (rd_valid_reg && !visited_reg[rd_idx_reg]) &&
                       (!have_reg || rd_data < best_cost_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            n_reg        <= '0;
            pos_reg      <= '0;
            cur_reg      <= '0;
            first_reg    <= '0;
            idx_reg      <= '0;
            visited_reg  <= '0;
            rd_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == ST_SCAN);
            rd_idx_reg   <= idx_reg;
            if (take) begin
                have_reg      <= 1'b1;
                best_reg      <= rd_idx_reg;
                best_cost_reg <= rd_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        n_reg        <= CNT_BITS'(n_sat);
                        cur_reg      <= NODE_BITS'(start_sat);
                        first_reg    <= NODE_BITS'(start_sat);
                        visited_reg  <= MAX_NODES'(1) << NODE_BITS'(start_sat);
                        pos_reg      <= CNT_BITS'(1);
                        res_reg.node <= 4'(start_sat);
                        res_reg.cost <= '0;
                        res_reg.last <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (res_ready) begin
                        if (res_reg.last) begin
                            state_reg <= ST_IDLE;
                        end else if (pos_reg == n_reg) begin
                            state_reg <= ST_CLOSE_RD;
                        end else begin
                            idx_reg   <= '0;
                            have_reg  <= 1'b0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    idx_reg <= idx_reg + NODE_BITS'(1);
                    if (scan_last) begin
                        state_reg <= ST_SCAN_WAIT;
                    end
                end
                ST_SCAN_WAIT: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    visited_reg  <= visited_reg | (MAX_NODES'(1) << best_reg);
                    cur_reg      <= best_reg;
                    pos_reg      <= pos_reg + CNT_BITS'(1);
                    res_reg.node <= 4'(best_reg);
                    res_reg.cost <= 32'(best_cost_reg);
                    res_reg.last <= 1'b0;
                    state_reg    <= ST_EMIT;
                end
                ST_CLOSE_RD: begin
                    state_reg <= ST_CLOSE_WAIT;
                end
                ST_CLOSE_WAIT: begin
                    cur_reg      <= first_reg;
                    res_reg.node <= 4'(first_reg);
                    res_reg.cost <= 32'(rd_data);
                    res_reg.last <= 1'b1;
                    state_reg    <= ST_EMIT;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rd_en     = (state_reg == ST_SCAN) || (state_reg == ST_CLOSE_RD);
    assign rd_addr   = (state_reg == ST_CLOSE_RD) ? {cur_reg, first_reg} : {cur_reg, idx_reg};
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;

    a_rd_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_SCAN_WAIT))
        else $error("scan read data outside of a scan");

    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> (have_reg && !visited_reg[best_reg]))
        else $error("no unvisited candidate at end of scan");

    a_visited_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ($countones(visited_reg) == 32'(pos_reg)))
        else $error("visited set out of step with tour position");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && res.last) |=> (state_reg == ST_IDLE))
        else $error("tour continued past closing result");

endmodule

>>> design/nearest_neighbour_tour.sv
// Load transaction: one per cycle when idle, written to the cost memory at the accepting edge.
// Start transaction: n+1 results; each greedy step does one cost memory read per candidate
// plus compare, update and emit.
// Input is not accepted while a tour runs; the next item follows the closing result.
// aresetn (synchronous, active low) clears control state and sets node_count to 16;
// cost memory contents are undefined until written.
module nearest_neighbour_tour #(
    parameter int MAX_NODES = nnt_pkg::MAX_NODES_DEF,
    parameter int COST_BITS = nnt_pkg::COST_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,  // from_node, to_node, edge_cost, start_node
    input  logic                               s_tuser,  // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,  // tour_node, step_cost
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nnt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nnt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nnt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import nnt_pkg::*;

    localparam int NODE_BITS = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * NODE_BITS;

    logic [NODE_COUNT_W-1:0] node_count_reg;
    logic                    m_tvalid_reg;
    res_t                    m_data_reg;

    logic [3:0]              from_node;
    logic [3:0]              to_node;
    logic [31:0]             edge_cost;
    logic [3:0]              start_node;
    logic [31:0]             row_ext;
    logic [31:0]             col_ext;
    logic                    in_take;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [COST_BITS-1:0]    rd_data;
    logic                    busy;
    logic                    res_valid;
    res_t                    res;
    logic                    res_ready;

    assign from_node  = s_tdata[3:0];
    assign to_node    = s_tdata[7:4];
    assign edge_cost  = s_tdata[39:8];
    assign start_node = s_tdata[43:40];
    assign row_ext    = 32'(from_node);
    assign col_ext    = 32'(to_node);

    assign s_tready = !busy;
    assign in_take  = s_tvalid && s_tready;
    assign wr_en    = in_take && (s_tuser == REQ_LOAD) &&
                      (row_ext < 32'(MAX_NODES)) && (col_ext < 32'(MAX_NODES));
    assign wr_addr  = {row_ext[NODE_BITS-1:0], col_ext[NODE_BITS-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
            node_count_reg <= pwdata[NODE_COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? APB_DATA_W'(node_count_reg) : '0;

    nnt_cost_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (COST_BITS)
    ) u_cost_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (COST_BITS'(edge_cost)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nnt_scan #(
        .MAX_NODES (MAX_NODES),
        .COST_BITS (COST_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (in_take && (s_tuser == REQ_START)),
        .node_count (node_count_reg),
        .start_node (start_node),
        .busy       (busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
            if (res_valid) begin
                m_data_reg <= res;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_data_reg.cost, m_data_reg.node};
    assign m_tlast  = m_data_reg.last;

endmodule

>>> tb/nnt_tour_checker.sv
`timescale 1ns / 100ps

module nnt_tour_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // from_node, to_node, edge_cost, start_node
    input  logic        s_tuser,   // req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // tour_node, step_cost
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [nnt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nnt_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [nnt_pkg::APB_DATA_W-1:0] prdata,
    input  logic        pready,
    input  logic        run_done,
    output int          fail_count,
    output int          pending
);
    import nnt_pkg::*;

    localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};

    logic [31:0]           cost_mem [16][16];
    logic [NODE_COUNT_W-1:0] count_reg;
    res_t                  tour_expected[$];
    bit                    done_seen;
    res_t                  want;

    task automatic report(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic push_result(input logic [3:0] node, input logic [31:0] cost,
                               input logic fin);
        res_t r;
        r.node = node;
        r.cost = cost;
        r.last = fin;
        tour_expected.insert(tour_expected.size(), r);
    endtask

    task automatic plan_tour(input logic [3:0] start_raw);
        int          n;
        int          pos;
        int          i;
        logic [15:0] seen;
        logic [3:0]  first;
        logic [3:0]  here;
        logic [3:0]  best;
        logic [31:0] best_cost;
        bit          have;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > 16) n = 16;
        first = (start_raw >= n) ? 4'(n - 1) : start_raw;
        here = first;
        seen = 16'd1 << first;
        push_result(first, 32'd0, 1'b0);
        for (pos = 1; pos < n; pos++) begin
            have = 0;
            best = 0;
            best_cost = 0;
            for (i = 0; i < n; i++) begin
                if (!seen[i] && (!have || cost_mem[here][i] < best_cost)) begin
                    have = 1;
                    best = 4'(i);
                    best_cost = cost_mem[here][i];
                end
            end
            seen[best] = 1'b1;
            here = best;
            push_result(best, best_cost, 1'b0);
        end
        push_result(first, cost_mem[here][first], 1'b1);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            count_reg = NODE_COUNT_RST;
            tour_expected.delete();
            done_seen = 0;
            fail_count = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == NODE_COUNT_ADDR) count_reg = pwdata[NODE_COUNT_W-1:0];
                end else if (prdata !== APB_DATA_W'(count_reg)) begin
                    report($sformatf("node_count read %0d, want %0d", prdata, count_reg));
                end
            end
            if (s_tvalid && s_tready) begin
                if (req_t'(s_tuser) == REQ_LOAD)
                    cost_mem[s_tdata[3:0]][s_tdata[7:4]] = s_tdata[39:8];
                else
                    plan_tour(s_tdata[43:40]);
            end
            if (m_tvalid && m_tready) begin
                if (tour_expected.size() == 0) begin
                    report($sformatf("unexpected result node %0d cost %0d last %0b",
                                     m_tdata[3:0], m_tdata[35:4], m_tlast));
                end else begin
                    want = tour_expected.pop_front();
                    if (m_tdata[3:0] !== want.node)
                        report($sformatf("tour_node %0d, want %0d", m_tdata[3:0], want.node));
                    if (m_tdata[35:4] !== want.cost)
                        report($sformatf("step_cost %0d, want %0d", m_tdata[35:4], want.cost));
                    if (m_tlast !== want.last)
                        report($sformatf("last %0b, want %0b", m_tlast, want.last));
                end
            end
            if (run_done && !done_seen) begin
                done_seen = 1;
                if (tour_expected.size() != 0)
                    report($sformatf("%0d results never arrived", tour_expected.size()));
            end
        end
        pending = tour_expected.size();
    end

endmodule

>>> tb/tb_nearest_neighbour_tour.sv
`timescale 1ns / 100ps

module tb_nearest_neighbour_tour;
    import nnt_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // from_node, to_node, edge_cost, start_node
    logic        s_tuser = 1'b0; // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // tour_node, step_cost
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;
    logic        run_done = 1'b0;
    logic        hold_go = 1'b0;
    int          hold_left;
    int          fail_count;
    int          pending;
    int          quiet_cycles;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          eff_n = 16;
    bit          loaded [16][16];

    always #5 aclk = ~aclk;

    nearest_neighbour_tour uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    nnt_tour_checker tour_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .run_done   (run_done),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_go) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(input req_t kind, input logic [3:0] from_n,
                             input logic [3:0] to_n, input logic [31:0] cost,
                             input logic [3:0] start_n);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'd0, start_n, cost, to_n, from_n};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic load_cost(input logic [3:0] from_n, input logic [3:0] to_n,
                             input logic [31:0] cost);
        send_item(REQ_LOAD, from_n, to_n, cost, 4'($urandom_range(15)));
        loaded[from_n][to_n] = 1'b1;
    endtask

    task automatic start_tour(input logic [3:0] start_n);
        send_item(REQ_START, 4'($urandom_range(15)), 4'($urandom_range(15)), $urandom(),
                  start_n);
    endtask

    function automatic logic [31:0] pick_cost();
        case ($urandom_range(4))
            0: return 32'($urandom_range(3));
            1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [4:0] pick_count();
        case ($urandom_range(4))
            0: return 5'd0;
            1: return 5'd1;
            default: return 5'($urandom_range(6, 2));
        endcase
    endfunction

    // write every off-diagonal entry a tour over n nodes can read that is not yet loaded
    task automatic fill_matrix(input int n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (i != j && !loaded[i][j]) load_cost(4'(i), 4'(j), pick_cost());
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= NODE_COUNT_ADDR;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_node_count(input logic [4:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        apb_access(1'b1, {27'($urandom()), value});
        apb_access(1'b0, '0);
        eff_n = (value < 2) ? 2 : (value > 16) ? 16 : value;
    endtask

    task automatic run_tour();
        int         k;
        logic [3:0] a;
        logic [3:0] b;
        k = $urandom_range(4);
        repeat (k) begin
            if ($urandom_range(3) == 0) begin
                a = 4'($urandom_range(15));
                b = 4'($urandom_range(15));
            end else begin
                a = 4'($urandom_range(eff_n - 1));
                b = 4'($urandom_range(eff_n - 1));
            end
            load_cost(a, b, pick_cost());
        end
        fill_matrix(eff_n);
        start_tour(4'($urandom_range(15)));
        if ($urandom_range(3) == 0) start_tour(4'($urandom_range(15)));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value, then the two-node tour from both ends and saturated
        apb_access(1'b0, '0);
        set_node_count(5'd2);
        load_cost(4'd0, 4'd1, 32'h0);
        load_cost(4'd1, 4'd0, 32'hFFFF_FFFF);
        start_tour(4'd0);
        start_tour(4'd1);
        start_tour(4'd15);
        set_node_count(5'd0);
        start_tour(4'd0);

        // equal costs keep the lowest index, then a row at the maximum
        set_node_count(5'd4);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                if (i != j) load_cost(4'(i), 4'(j), 32'd5);
        start_tour(4'd2);
        load_cost(4'd2, 4'd0, 32'hFFFF_FFFF);
        load_cost(4'd2, 4'd1, 32'hFFFF_FFFF);
        load_cost(4'd2, 4'd3, 32'hFFFF_FFFF);
        start_tour(4'd2);

        // hold the result side so the input backs up
        set_node_count(5'd6);
        fill_matrix(6);
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        start_tour(4'($urandom_range(15)));
        repeat (6)
            load_cost(4'($urandom_range(15)), 4'($urandom_range(15)), pick_cost());
        start_tour(4'($urandom_range(15)));

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct <= 66; sink_stall_pct <= 0;  end
                2: begin src_idle_pct <= 0;  sink_stall_pct <= 66; end
                default: begin src_idle_pct <= 28; sink_stall_pct <= 28; end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                set_node_count(pick_count());
                repeat (3) run_tour();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        run_done <= 1'b1;
        repeat (3) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> nearest_neighbour_tour.f
design/nnt_pkg.sv
design/nnt_cost_ram.sv
design/nnt_scan.sv
design/nearest_neighbour_tour.sv
tb/nnt_tour_checker.sv
tb/tb_nearest_neighbour_tour.sv
